>>> src/ufs_pkg.sv
// ============================================================================
// ufs_pkg
// Shared types, constants and the character classifier and field resolver
// of the URL field splitter.
// ============================================================================
package ufs_pkg;

    // Scheme buffer and port limits
    localparam int SCHEME_MAX = 9;
    localparam int PORT_MAX   = 4;
    localparam int CNT_W      = $clog2(SCHEME_MAX + 1);
    localparam int IDX_W      = (SCHEME_MAX > 1) ? $clog2(SCHEME_MAX) : 1;
    localparam int PC_W       = $clog2(PORT_MAX + 1);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Delimiter characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // Field codes on the output
    typedef logic [2:0] field_t;
    localparam field_t F_SCHEME = 3'd0;
    localparam field_t F_DOMAIN = 3'd1;
    localparam field_t F_PORT   = 3'd2;
    localparam field_t F_PATH   = 3'd3;
    localparam field_t F_QUERY  = 3'd4;
    localparam field_t F_FRAG   = 3'd5;

    typedef enum logic [2:0] {
        CC_LETTER,
        CC_DOMSYM,   // digit, '.' or '-'
        CC_COLON,
        CC_SLASH,
        CC_QMARK,
        CC_HASH,
        CC_OTHER
    } char_class_t;

    typedef enum logic [2:0] {
        M_SCHEME,
        M_SLASH,
        M_DOMAIN,
        M_PORTCHK,
        M_PORT,
        M_PATH,
        M_QUERY,
        M_FRAG
    } mode_t;

    typedef enum logic [1:0] {
        PH_PROC,
        PH_REPLAY,
        PH_END
    } phase_t;

    typedef enum logic [1:0] {
        RK_COLON,    // confirmed scheme, item done afterwards
        RK_REPROC,   // letters become domain, character examined again
        RK_END       // letters become domain at the URL end
    } replay_kind_t;

    typedef struct packed {
        logic [7:0]  ch;
        char_class_t cls;
        logic        last;
    } q_entry_t;

    typedef struct packed {
        logic [7:0] ch;
        field_t     fld;
        logic       valid;
        logic       done;
        logic       last;
    } result_t;

    typedef struct packed {
        logic            emit;
        field_t          fld;
        mode_t           mode;
        logic [PC_W-1:0] pc;
    } resolve_t;

    // Sort one byte into the classes the parser cares about
    function automatic char_class_t classify(logic [7:0] c);
        char_class_t cls;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
            cls = CC_LETTER;
        else if ((c >= 8'h30 && c <= 8'h39) || c == CH_DOT || c == CH_DASH)
            cls = CC_DOMSYM;
        else if (c == CH_COLON)
            cls = CC_COLON;
        else if (c == CH_SLASH)
            cls = CC_SLASH;
        else if (c == CH_QMARK)
            cls = CC_QMARK;
        else if (c == CH_HASH)
            cls = CC_HASH;
        else
            cls = CC_OTHER;
        return cls;
    endfunction

    // Walk the fall-through chain of the non-scheme modes for one character
    function automatic resolve_t resolve(mode_t m_in, char_class_t cls,
                                         logic [PC_W-1:0] pc_in);
        resolve_t r;
        mode_t    m;
        logic     done;
        r.emit = 1'b0;
        r.fld  = F_SCHEME;
        r.pc   = pc_in;
        m      = m_in;
        done   = 1'b0;
        if (m == M_SLASH)
        begin
            if (cls == CC_SLASH)
                done = 1'b1;
            else
                m = M_DOMAIN;
        end
        if (!done && m == M_DOMAIN)
        begin
            if (cls == CC_SLASH)
            begin
                m    = M_PORTCHK;
                done = 1'b1;
            end
            else if (cls == CC_LETTER || cls == CC_DOMSYM)
            begin
                r.emit = 1'b1;
                r.fld  = F_DOMAIN;
                done   = 1'b1;
            end
            else
                m = M_PORTCHK;
        end
        if (!done && m == M_PORTCHK)
        begin
            if (cls == CC_COLON)
            begin
                m    = M_PORT;
                r.pc = '0;
                done = 1'b1;
            end
            else
                m = M_PATH;
        end
        if (!done && m == M_PORT)
        begin
            if (cls == CC_SLASH || r.pc >= PC_W'(PORT_MAX))
                m = M_PATH;
            else
            begin
                r.emit = 1'b1;
                r.fld  = F_PORT;
                r.pc   = r.pc + PC_W'(1);
                done   = 1'b1;
            end
        end
        if (!done && m == M_PATH)
        begin
            if (cls == CC_QMARK)
                m = M_QUERY;
            else if (cls == CC_HASH)
                m = M_FRAG;
            else
            begin
                r.emit = 1'b1;
                r.fld  = F_PATH;
            end
            done = 1'b1;
        end
        if (!done && m == M_QUERY)
        begin
            if (cls == CC_HASH)
                m = M_FRAG;
            else
            begin
                r.emit = 1'b1;
                r.fld  = F_QUERY;
            end
            done = 1'b1;
        end
        if (!done && m == M_FRAG)
        begin
            r.emit = 1'b1;
            r.fld  = F_FRAG;
        end
        r.mode = m;
        return r;
    endfunction

endpackage

>>> src/url_field_splitter.sv
// ============================================================================
// url_field_splitter
// Tags each URL character as scheme, domain, port, path, query or fragment.
// ============================================================================
//
//  channel  dir  tdata          tuser                               tlast
//  s_*      in   in_char[7:0]   -                                   url_end
//  m_*      out  out_char[7:0]  field[2:0] char_valid[3] done[4]    run_last
//
//  Held scheme letters are replayed one by one in the parser sequencer, and
//  each URL closes with an end marker; the back emits one result per cycle
//  through its output register while m_tready does not stall it.
//  Reset is asynchronous and returns the parser to scheme collection.
//  A two-entry queue keeps accepting input while the output is stalled, until it is full.
//
module url_field_splitter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_char
    input  logic       s_tlast,    // url_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_char
    output logic [4:0] m_tuser,    // [2:0] field, [3] char_valid, [4] url_done
    output logic       m_tlast     // run_last
);
    import ufs_pkg::*;

    logic     push;
    logic     q_ready;
    logic     q_valid;
    logic     pop;
    q_entry_t push_entry;
    q_entry_t head;

    ufs_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_ready    (q_ready),
        .push       (push),
        .push_entry (push_entry)
    );

    ufs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    ufs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // End marker carries no character and closes the run
    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4] |-> !m_tuser[3] && m_tlast && m_tdata == 8'h00
                                   && m_tuser[2:0] == F_SCHEME)
        else $error("end marker malformed");

    // Character results use only the six field codes
    a_field_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] <= F_FRAG && !m_tuser[4])
        else $error("bad field code on character result");

    // Back only retires items that are in the queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

>>> src/ufs_front.sv
// ============================================================================
// ufs_front
// Input side: classifies each accepted character and pushes it with its
// class and end flag into the queue.
// ============================================================================
module ufs_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] in_char
    input  logic              s_tlast,    // url_end
    input  logic              q_ready,
    output logic              push,
    output ufs_pkg::q_entry_t push_entry
);
    import ufs_pkg::*;

    // Accept whenever the queue has room
    assign s_tready = q_ready;
    assign push     = s_tvalid && q_ready;

    // Classify the word on its way in
    always_comb
    begin
        push_entry.ch   = s_tdata;
        push_entry.cls  = classify(s_tdata);
        push_entry.last = s_tlast;
    end

endmodule

>>> src/ufs_queue.sv
// ============================================================================
// ufs_queue
// Short FIFO of classified characters between the front and the back.
// ============================================================================
module ufs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ufs_pkg::q_entry_t push_entry,
    output logic              q_ready,
    input  logic              pop,
    output logic              q_valid,
    output ufs_pkg::q_entry_t head
);
    import ufs_pkg::*;

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign q_ready = (count_reg != QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> src/ufs_back.sv
// ============================================================================
// ufs_back
// Parser sequencer: takes classified characters from the queue, holds
// scheme letters, replays them one per cycle unless the output stalls, and
// emits tagged results through a single output register.
// ============================================================================
module ufs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  ufs_pkg::q_entry_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,    // [7:0] out_char
    output logic [4:0]        m_tuser,    // [2:0] field, [3] char_valid, [4] url_done
    output logic              m_tlast     // run_last
);
    import ufs_pkg::*;

    phase_t            phase_reg, phase_next;
    mode_t             mode_reg, mode_next;
    replay_kind_t      kind_reg, kind_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [7:0]        buf_reg [SCHEME_MAX];
    logic              buf_we;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           res;
    logic              load;

    logic              can_load;
    logic              is_letter;
    logic              is_colon;
    logic              is_scheme;
    logic              cnt_full;
    logic              cnt_zero;
    logic              sch_store;
    logic              sch_replay_dom;
    logic              proc_go;
    logic              proc_emit;
    logic              idx_last;
    logic              more_after;
    resolve_t          r;
    resolve_t          dom_r;

    // Decode the head character against the current mode
    assign can_load       = !out_valid_reg || m_tready;
    assign is_letter      = (head.cls == CC_LETTER);
    assign is_colon       = (head.cls == CC_COLON);
    assign is_scheme      = (mode_reg == M_SCHEME);
    assign cnt_full       = (cnt_reg == CNT_W'(SCHEME_MAX));
    assign cnt_zero       = (cnt_reg == '0);
    assign sch_store      = is_letter && !cnt_full;
    assign sch_replay_dom = (is_letter && cnt_full) || (!is_letter && !is_colon && !cnt_zero);
    assign r              = resolve(is_scheme ? M_SLASH : mode_reg, head.cls, pc_reg);
    assign dom_r          = resolve(M_DOMAIN, head.cls, pc_reg);
    assign proc_go        = (phase_reg == PH_PROC) && q_valid && can_load;
    assign proc_emit      = is_scheme ? (!is_letter && !is_colon && cnt_zero && r.emit)
                                      : r.emit;
    assign idx_last       = (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));

    // Tell whether more results of this item follow the replayed letters
    always_comb
    begin
        unique case (kind_reg)
            RK_COLON:  more_after = head.last;
            RK_REPROC: more_after = head.last || dom_r.emit;
            RK_END:    more_after = 1'b1;
            default:   more_after = 1'b1;
        endcase
    end

    // Next state of the sequencer and parser
    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pc_next    = pc_reg;
        pop        = 1'b0;
        buf_we     = 1'b0;
        unique case (phase_reg)
            PH_PROC:
            begin
                if (proc_go)
                begin
                    if (is_scheme && sch_store)
                    begin
                        buf_we   = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (head.last)
                        begin
                            phase_next = PH_REPLAY;
                            kind_next  = RK_END;
                            idx_next   = '0;
                        end
                        else
                            pop = 1'b1;
                    end
                    else if (is_scheme && sch_replay_dom)
                    begin
                        mode_next  = M_DOMAIN;
                        phase_next = PH_REPLAY;
                        kind_next  = RK_REPROC;
                        idx_next   = '0;
                    end
                    else if (is_scheme && is_colon)
                    begin
                        mode_next = M_SLASH;
                        if (!cnt_zero)
                        begin
                            phase_next = PH_REPLAY;
                            kind_next  = RK_COLON;
                            idx_next   = '0;
                        end
                        else if (head.last)
                            phase_next = PH_END;
                        else
                            pop = 1'b1;
                    end
                    else
                    begin
                        mode_next = r.mode;
                        pc_next   = r.pc;
                        if (head.last)
                            phase_next = PH_END;
                        else
                            pop = 1'b1;
                    end
                end
            end
            PH_REPLAY:
            begin
                if (can_load)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_last)
                    begin
                        cnt_next = '0;
                        unique case (kind_reg)
                            RK_COLON:
                            begin
                                if (head.last)
                                    phase_next = PH_END;
                                else
                                begin
                                    pop        = 1'b1;
                                    phase_next = PH_PROC;
                                end
                            end
                            RK_REPROC: phase_next = PH_PROC;
                            default:   phase_next = PH_END;
                        endcase
                    end
                end
            end
            PH_END:
            begin
                if (can_load)
                begin
                    mode_next  = M_SCHEME;
                    cnt_next   = '0;
                    pc_next    = '0;
                    pop        = 1'b1;
                    phase_next = PH_PROC;
                end
            end
            default: phase_next = PH_PROC;
        endcase
    end

    // Result word for the output register
    always_comb
    begin
        load = 1'b0;
        res  = '0;
        unique case (phase_reg)
            PH_PROC:
            begin
                if (proc_go && proc_emit)
                begin
                    load      = 1'b1;
                    res.ch    = head.ch;
                    res.fld   = r.fld;
                    res.valid = 1'b1;
                    res.last  = !head.last;
                end
            end
            PH_REPLAY:
            begin
                if (can_load)
                begin
                    load      = 1'b1;
                    res.ch    = buf_reg[idx_reg];
                    res.fld   = (kind_reg == RK_COLON) ? F_SCHEME : F_DOMAIN;
                    res.valid = 1'b1;
                    res.last  = idx_last && !more_after;
                end
            end
            PH_END:
            begin
                if (can_load)
                begin
                    load     = 1'b1;
                    res.done = 1'b1;
                    res.last = 1'b1;
                end
            end
            default: load = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PROC;
            mode_reg      <= M_SCHEME;
            kind_reg      <= RK_COLON;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            pc_reg    <= pc_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold scheme letters and the outgoing word
    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_reg[cnt_reg[IDX_W-1:0]] <= head.ch;
        if (load)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.ch;
    assign m_tuser  = {out_reg.done, out_reg.valid, out_reg.fld};
    assign m_tlast  = out_reg.last;

endmodule
